>>> rtl/core/uartrx_pkg.sv
// shared types and constants of the uart receive unit
// no dependencies
package uartrx_pkg;

    localparam int MAX_DATA_BITS = 8;
    localparam int PERIOD_WIDTH  = 16;
    localparam int BIT_IDX_W     = 4;
    localparam int DATA_IDX_W    = $clog2(MAX_DATA_BITS);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [PERIOD_WIDTH-1:0] MIN_PERIOD = PERIOD_WIDTH'(4);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HALF   = 2'd3;

    // parity selector codes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FRAME  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PARITY = 2'd2;

    // effective (clamped) settings seen by the receiver
    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] period;
        logic [PERIOD_WIDTH-1:0] half_period;
        logic [PERIOD_WIDTH-1:0] extra;
        logic [BIT_IDX_W-1:0]    data_bits;
        logic                    parity_en;
        logic                    parity_odd;
    } cfg_eff_t;

    typedef struct packed {
        logic                     valid;
        logic [MAX_DATA_BITS-1:0] rx_byte;
        logic [STATUS_W-1:0]      rx_status;
    } result_t;

endpackage

>>> rtl/core/uart_receive_with_parity_and_stop_check_unit.sv
// top level of the uart receive unit: config registers, frame sequencer, result buffer
// depends on uartrx_pkg, uartrx_cfg, uartrx_core, uartrx_obuf
// a frame result is registered in the result buffer when its deciding sample is taken
// throughput: one line sample per cycle; s_tready drops only while both result slots are full
// reset: rst_n asynchronous active low; sequencer waits for an idle-high line, registers
//   return to 16 samples per bit, 8 data bits, no parity, one stop bit
module uart_receive_with_parity_and_stop_check_unit
    import uartrx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] line_level, [7:1] zero
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] rx_byte, [9:8] rx_status, [15:10] zero
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_eff_t                 eff;
    result_t                  res;
    logic                     space;
    logic                     sample_valid;
    logic [MAX_DATA_BITS-1:0] out_byte;
    logic [STATUS_W-1:0]      out_status;

    // a sample transaction is taken whenever the skid slot is free
    assign s_tready     = space;
    assign sample_valid = s_tvalid && space;

    uartrx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    // all per-sample decisions happen here, state registered on each accepted sample
    uartrx_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .eff          (eff),
        .sample_valid (sample_valid),
        .level        (s_tdata[0]),
        .res          (res)
    );

    // result register plus skid entry decouple the two sides
    uartrx_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .space      (space),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_status (out_status)
    );

    assign m_tdata = {(OUT_TDATA_W - MAX_DATA_BITS - STATUS_W)'(0), out_status, out_byte};

endmodule

>>> rtl/core/uartrx_cfg.sv
// configuration registers of the uart receive unit and their clamped values
// depends on uartrx_pkg
module uartrx_cfg
    import uartrx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_eff_t              eff
);

    logic [PERIOD_WIDTH-1:0] period_reg;
    logic [3:0]              data_bits_reg;
    logic [1:0]              parity_reg;
    logic [2:0]              stop_half_reg;

    logic [PERIOD_WIDTH-1:0] period_c;
    logic [2:0]              stop_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_WIDTH'(16);
            data_bits_reg <= 4'd8;
            parity_reg    <= PAR_NONE;
            stop_half_reg <= 3'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_PERIOD:  period_reg    <= cfg_data[PERIOD_WIDTH-1:0];
                REG_DATA_BITS:   data_bits_reg <= cfg_data[3:0];
                REG_PARITY_MODE: parity_reg    <= cfg_data[1:0];
                REG_STOP_HALF:   stop_half_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        period_c = (period_reg < MIN_PERIOD) ? MIN_PERIOD : period_reg;
        if (stop_half_reg < 3'd2)
            stop_c = 3'd2;
        else if (stop_half_reg > 3'd4)
            stop_c = 3'd4;
        else
            stop_c = stop_half_reg;

        eff.period      = period_c;
        eff.half_period = period_c >> 1;
        // extra stop interval: 0, (p+1)/2 or p for 1, 1.5 or 2 stop bits
        case (stop_c)
            3'd3:    eff.extra = (period_c >> 1) + PERIOD_WIDTH'(period_c[0]);
            3'd4:    eff.extra = period_c;
            default: eff.extra = '0;
        endcase
        if (data_bits_reg == 4'd0)
            eff.data_bits = 4'd1;
        else if (data_bits_reg > BIT_IDX_W'(MAX_DATA_BITS))
            eff.data_bits = BIT_IDX_W'(MAX_DATA_BITS);
        else
            eff.data_bits = data_bits_reg;
        eff.parity_en  = (parity_reg == PAR_EVEN) || (parity_reg == PAR_ODD);
        eff.parity_odd = (parity_reg == PAR_ODD);
    end

endmodule

>>> rtl/core/uartrx_core.sv
// frame sequencer of the uart receive unit: one line sample per cycle while sample_valid is high
// depends on uartrx_pkg
module uartrx_core
    import uartrx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_eff_t eff,
    input  logic     sample_valid,
    input  logic     level,
    output result_t  res
);

    typedef enum logic [2:0] {
        PH_WAIT_HIGH = 3'd0,
        PH_IDLE      = 3'd1,
        PH_START     = 3'd2,
        PH_DATA      = 3'd3,
        PH_PARITY    = 3'd4,
        PH_STOP      = 3'd5,
        PH_HOLD      = 3'd6
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [PERIOD_WIDTH-1:0]  tick_reg, tick_next;
    logic [BIT_IDX_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [MAX_DATA_BITS-1:0] shift_reg, shift_next;
    logic                     par_reg, par_next;
    logic [STATUS_W-1:0]      err_reg, err_next;
    logic                     last_reg;

    logic [PERIOD_WIDTH-1:0]  tick_inc;
    logic [PERIOD_WIDTH-1:0]  threshold;
    logic                     hit;
    logic                     par_bit;
    logic                     finish;
    logic [MAX_DATA_BITS-1:0] fin_byte;

    always_comb
    begin
        tick_inc = tick_reg + PERIOD_WIDTH'(1);
        case (phase_reg)
            PH_START: threshold = eff.half_period;
            PH_HOLD:  threshold = eff.extra;
            default:  threshold = eff.period;
        endcase
        hit     = (tick_inc >= threshold);
        par_bit = par_reg ^ level;

        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        par_next     = par_reg;
        err_next     = err_reg;
        finish       = 1'b0;
        fin_byte     = shift_reg;

        case (phase_reg)
            PH_WAIT_HIGH:
            begin
                if (level)
                    phase_next = PH_IDLE;
            end
            PH_IDLE:
            begin
                if (!level && last_reg)
                begin
                    phase_next   = PH_START;
                    tick_next    = '0;
                    bit_idx_next = '0;
                    shift_next   = '0;
                    par_next     = 1'b0;
                    err_next     = ST_OK;
                end
            end
            PH_START:
            begin
                tick_next = tick_inc;
                if (hit)
                begin
                    tick_next = '0;
                    if (level)
                    begin
                        // start bit gone high before its centre
                        finish   = 1'b1;
                        fin_byte = '0;
                        err_next = ST_FRAME;
                    end
                    else
                        phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                tick_next = tick_inc;
                if (hit)
                begin
                    tick_next = '0;
                    if (bit_idx_reg < BIT_IDX_W'(MAX_DATA_BITS))
                        shift_next[bit_idx_reg[DATA_IDX_W-1:0]] =
                            shift_reg[bit_idx_reg[DATA_IDX_W-1:0]] | level;
                    par_next     = par_bit;
                    bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                    if (bit_idx_next >= eff.data_bits)
                        phase_next = eff.parity_en ? PH_PARITY : PH_STOP;
                end
            end
            PH_PARITY:
            begin
                tick_next = tick_inc;
                if (hit)
                begin
                    tick_next = '0;
                    if (eff.parity_en && (eff.parity_odd ? !par_bit : par_bit))
                        err_next = ST_PARITY;
                    phase_next = PH_STOP;
                end
            end
            PH_STOP:
            begin
                tick_next = tick_inc;
                if (hit)
                begin
                    tick_next = '0;
                    if (!level)
                        err_next = ST_FRAME;
                    if (eff.extra == '0)
                        finish = 1'b1;
                    else
                        phase_next = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                if (level != last_reg)
                    err_next = ST_FRAME;
                tick_next = tick_inc;
                if (hit)
                    finish = 1'b1;
            end
            default:
            begin
                phase_next = level ? PH_IDLE : PH_WAIT_HIGH;
            end
        endcase

        if (finish)
        begin
            phase_next = level ? PH_IDLE : PH_WAIT_HIGH;
            tick_next  = '0;
        end

        res.valid     = sample_valid && finish;
        res.rx_byte   = fin_byte;
        res.rx_status = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT_HIGH;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            par_reg     <= 1'b0;
            err_reg     <= ST_OK;
            last_reg    <= 1'b1;
        end
        else if (sample_valid)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            par_reg     <= par_next;
            err_reg     <= err_next;
            last_reg    <= level;
        end
    end

endmodule

>>> rtl/core/uartrx_obuf.sv
// result register with skid stage of the uart receive unit
// depends on uartrx_pkg
module uartrx_obuf
    import uartrx_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  result_t                  res,
    output logic                     space,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [MAX_DATA_BITS-1:0] out_byte,
    output logic [STATUS_W-1:0]      out_status
);

    logic                     main_valid_reg;
    logic                     skid_valid_reg;
    logic [MAX_DATA_BITS-1:0] main_byte_reg, skid_byte_reg;
    logic [STATUS_W-1:0]      main_stat_reg, skid_stat_reg;
    logic                     pop;

    assign pop        = main_valid_reg && out_ready;
    assign space      = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_byte   = main_byte_reg;
    assign out_status = main_stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            main_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_byte_reg <= skid_byte_reg;
                main_stat_reg <= skid_stat_reg;
            end
        end
        else if (res.valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_byte_reg <= res.rx_byte;
                main_stat_reg <= res.rx_status;
            end
            else
            begin
                skid_byte_reg <= res.rx_byte;
                skid_stat_reg <= res.rx_status;
            end
        end
    end

endmodule

>>> rtl/core/uartrx_checker.sv
// port-level checks of the uart receive unit, bound to the top level
// depends on uartrx_pkg and uart_receive_with_parity_and_stop_check_unit
module uartrx_checker
    import uartrx_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // status is one of ok, framing, parity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:8] == ST_OK) || (m_tdata[9:8] == ST_FRAME) ||
                     (m_tdata[9:8] == ST_PARITY))
        else $error("bad status code");

    // sample side only stalls while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("sample stall with empty result buffer");

    // back-pressure clears in the cycle after the pending result is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("stall did not clear after result was taken");

    // a result only appears after a sample transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without a preceding sample");

endmodule

bind uart_receive_with_parity_and_stop_check_unit uartrx_checker u_uartrx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/testbench.sv
// self-checking testbench for the uart receive unit, one line sample per input transaction
// depends on uartrx_pkg and uart_receive_with_parity_and_stop_check_unit
// a built-in line decoder predicts every character and the result stream is checked in order
`timescale 1ns / 1ps

module testbench;
    import uartrx_pkg::*;

    // watchdog cycle limit, with a wide margin over what a correct run needs
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned MAX_GAP     = 13;
    // line samples to send over the whole run
    localparam int unsigned ITEM_TARGET = 1550;

    // decoder phases, mirroring how the receiver walks through a character
    typedef enum logic [2:0] {
        LP_WAIT_HIGH,
        LP_IDLE,
        LP_START,
        LP_DATA,
        LP_PARITY,
        LP_STOP,
        LP_HOLD
    } line_phase_t;

    // ways a generated character can be spoilt
    typedef enum int {
        FF_NONE,
        FF_PARITY,
        FF_STOP_LOW,
        FF_PARITY_AND_STOP,
        FF_HOLD_GLITCH,
        FF_SHORT_START,
        FF_NOISE
    } frame_fault_t;

    typedef struct packed {
        logic [7:0]          rx_byte;
        logic [STATUS_W-1:0] rx_status;
    } rx_char_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // register copies as the decoder sees them
    logic [15:0] cfg_period;
    logic [3:0]  cfg_bits;
    logic [1:0]  cfg_parity;
    logic [2:0]  cfg_stop;

    // decoder state
    line_phase_t         line_phase;
    logic [23:0]         tick_cnt;
    logic [3:0]          bit_cnt;
    logic [7:0]          char_acc;
    logic                parity_sum;
    logic [STATUS_W-1:0] char_status;
    logic                prev_level;

    rx_char_t    pending_chars[$];
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned samples_sent = 0;
    int unsigned noise_pct    = 0;
    bit          src_gaps     = 1'b1;
    bit          sink_gaps    = 1'b1;

    uart_receive_with_parity_and_stop_check_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog against a stalled stream
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // line decoder: effective (clamped) settings
    // ------------------------------------------------------------------

    function automatic int unsigned eff_period();
        return (cfg_period < MIN_PERIOD) ? int'(MIN_PERIOD) : int'(cfg_period);
    endfunction

    function automatic int unsigned eff_data_bits();
        if (cfg_bits == 4'd0)
            return 1;
        if (cfg_bits > MAX_DATA_BITS)
            return MAX_DATA_BITS;
        return cfg_bits;
    endfunction

    function automatic int unsigned eff_stop_half();
        if (cfg_stop < 3'd2)
            return 2;
        if (cfg_stop > 3'd4)
            return 4;
        return cfg_stop;
    endfunction

    function automatic bit parity_on();
        return (cfg_parity == PAR_EVEN) || (cfg_parity == PAR_ODD);
    endfunction

    // samples after the stop centre over which the line must stay still
    function automatic int unsigned hold_ticks();
        return (eff_period() * (eff_stop_half() - 2) + 1) >> 1;
    endfunction

    function automatic void reset_decoder();
        cfg_period  = 16'd16;
        cfg_bits    = 4'd8;
        cfg_parity  = PAR_NONE;
        cfg_stop    = 3'd2;
        line_phase  = LP_WAIT_HIGH;
        tick_cnt    = '0;
        bit_cnt     = '0;
        char_acc    = '0;
        parity_sum  = 1'b0;
        char_status = ST_OK;
        prev_level  = 1'b1;
    endfunction

    function automatic void close_char(input logic level, input logic [7:0] data_val,
                                       input logic [STATUS_W-1:0] status);
        rx_char_t entry;
        entry.rx_byte   = data_val;
        entry.rx_status = status;
        pending_chars.insert(pending_chars.size(), entry);
        line_phase = level ? LP_IDLE : LP_WAIT_HIGH;
        tick_cnt   = '0;
    endfunction

    // advance the decoder by one accepted line sample
    function automatic void decode_sample(input logic level);
        logic prev;
        logic par;
        prev       = prev_level;
        prev_level = level;
        case (line_phase)
            LP_WAIT_HIGH:
            begin
                if (level)
                    line_phase = LP_IDLE;
            end
            LP_IDLE:
            begin
                // falling edge opens a character
                if (!level && prev)
                begin
                    line_phase  = LP_START;
                    tick_cnt    = '0;
                    bit_cnt     = '0;
                    char_acc    = '0;
                    parity_sum  = 1'b0;
                    char_status = ST_OK;
                end
            end
            LP_START:
            begin
                tick_cnt = (tick_cnt + 24'd1) & 24'hFFFF;
                if (tick_cnt >= (eff_period() >> 1))
                begin
                    tick_cnt = '0;
                    if (level)
                        close_char(level, 8'h00, ST_FRAME);
                    else
                        line_phase = LP_DATA;
                end
            end
            LP_DATA:
            begin
                tick_cnt = (tick_cnt + 24'd1) & 24'hFFFF;
                if (tick_cnt >= eff_period())
                begin
                    tick_cnt = '0;
                    if (bit_cnt < MAX_DATA_BITS)
                        char_acc = char_acc | (8'(level) << bit_cnt);
                    parity_sum = parity_sum ^ level;
                    bit_cnt    = bit_cnt + 4'd1;
                    if (bit_cnt >= eff_data_bits())
                        line_phase = parity_on() ? LP_PARITY : LP_STOP;
                end
            end
            LP_PARITY:
            begin
                tick_cnt = (tick_cnt + 24'd1) & 24'hFFFF;
                if (tick_cnt >= eff_period())
                begin
                    par      = parity_sum ^ level;
                    tick_cnt = '0;
                    if ((cfg_parity == PAR_EVEN && par) || (cfg_parity == PAR_ODD && !par))
                        char_status = ST_PARITY;
                    line_phase = LP_STOP;
                end
            end
            LP_STOP:
            begin
                tick_cnt = (tick_cnt + 24'd1) & 24'hFFFF;
                if (tick_cnt >= eff_period())
                begin
                    tick_cnt = '0;
                    // framing overrides parity
                    if (!level)
                        char_status = ST_FRAME;
                    if (hold_ticks() == 0)
                        close_char(level, char_acc, char_status);
                    else
                        line_phase = LP_HOLD;
                end
            end
            LP_HOLD:
            begin
                if (level != prev)
                    char_status = ST_FRAME;
                tick_cnt = tick_cnt + 24'd1;
                if (tick_cnt >= hold_ticks())
                    close_char(level, char_acc, char_status);
            end
            default:
            begin
                line_phase = level ? LP_IDLE : LP_WAIT_HIGH;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sample stream driver
    // ------------------------------------------------------------------

    // one line sample, returns just after the accepting edge with s_tvalid still high
    task automatic send_sample(input logic level);
        int unsigned gap;
        gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_tready);
        decode_sample(level);
        samples_sent++;
    endtask

    // drop s_tvalid at the negedge right after the last transaction
    task automatic release_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // run of equal samples, with optional random flips
    task automatic send_run(input logic level, input int unsigned count);
        repeat (count)
            send_sample(level ^ ($urandom_range(0, 99) < noise_pct));
    endtask

    // hold the line high until the decoder is back in idle
    task automatic flush_line();
        while (line_phase != LP_IDLE)
            send_sample(1'b1);
    endtask

    // wait for every predicted character, then for the result path to empty
    task automatic drain_results();
        flush_line();
        release_stream();
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // register write, only ever issued with the receiver idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_BIT_PERIOD:  cfg_period = value;
            REG_DATA_BITS:   cfg_bits   = value[3:0];
            REG_PARITY_MODE: cfg_parity = value[1:0];
            REG_STOP_HALF:   cfg_stop   = value[2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_format(input int unsigned period, input int unsigned bits,
                              input logic [1:0] parity, input int unsigned stop_half);
        write_reg(REG_BIT_PERIOD, CFG_DATA_W'(period));
        write_reg(REG_DATA_BITS, CFG_DATA_W'(bits));
        write_reg(REG_PARITY_MODE, CFG_DATA_W'(parity));
        write_reg(REG_STOP_HALF, CFG_DATA_W'(stop_half));
    endtask

    // one character on the line in the current format, possibly spoilt
    task automatic send_char(input logic [7:0] value, input frame_fault_t fault);
        int unsigned p;
        int unsigned nb;
        int unsigned lo;
        int unsigned g;
        logic        par;
        p         = eff_period();
        nb        = eff_data_bits();
        par       = (cfg_parity == PAR_ODD);
        noise_pct = (fault == FF_NOISE) ? $urandom_range(1, 8) : 0;
        send_run(1'b1, $urandom_range(1, 3));
        if (fault == FF_SHORT_START)
        begin
            // start bit gone before its centre
            lo = p / 2 - 1;
            if (lo > 40)
                lo = 40;
            send_run(1'b0, $urandom_range(1, lo));
            send_run(1'b1, p / 2 + 2);
        end
        else
        begin
            send_run(1'b0, p);
            for (int i = 0; i < nb; i++)
            begin
                send_run(value[i], p);
                par = par ^ value[i];
            end
            if (parity_on())
            begin
                if (fault == FF_PARITY || fault == FF_PARITY_AND_STOP)
                    par = ~par;
                send_run(par, p);
            end
            if (fault == FF_STOP_LOW || fault == FF_PARITY_AND_STOP)
                send_run(1'b0, p + $urandom_range(0, 2 * p));
            else if (fault == FF_HOLD_GLITCH && eff_stop_half() > 2)
            begin
                // one low sample somewhere in the extra stop interval
                g = p / 2 + $urandom_range(1, hold_ticks());
                send_run(1'b1, g);
                send_run(1'b0, 1);
                send_run(1'b1, p);
            end
            else
                send_run(1'b1, (p * eff_stop_half() + 1) / 2);
        end
        send_run(1'b1, 2);
        noise_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // result sink and checker
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int unsigned stall;
        rx_char_t    want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            // compare the transaction against the oldest pending character
            if (pending_chars.size() == 0)
            begin
                $error("unexpected result transaction, tdata %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata[7:0] !== want.rx_byte)
                begin
                    $error("rx_byte mismatch: expected %0h, actual %0h",
                           want.rx_byte, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[9:8] !== want.rx_status)
                begin
                    $error("rx_status mismatch: expected %0d, actual %0d",
                           want.rx_status, m_tdata[9:8]);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset format: 16 samples per bit, 8 data bits, no parity, one stop bit
    task automatic test_reset_format();
        send_char(8'hA5, FF_NONE);
    endtask

    // even and odd parity, good and bad, and framing winning over parity
    task automatic test_parity_check();
        set_format(4, 8, PAR_EVEN, 2);
        send_char(8'h01, FF_NONE);
        send_char(8'h01, FF_PARITY);
        write_reg(REG_PARITY_MODE, CFG_DATA_W'(PAR_ODD));
        send_char(8'h3C, FF_NONE);
        send_char(8'h3C, FF_PARITY);
        send_char(8'h5A, FF_PARITY_AND_STOP);
        // selector 3 means no parity bit
        write_reg(REG_PARITY_MODE, CFG_DATA_W'(2'd3));
        send_char(8'hC3, FF_NONE);
    endtask

    // one, one and a half and two stop bits, glitches and a low stop bit
    task automatic test_stop_lengths();
        set_format(4, 8, PAR_NONE, 2);
        send_char(8'h81, FF_STOP_LOW);
        write_reg(REG_STOP_HALF, CFG_DATA_W'(3));
        send_char(8'h7E, FF_NONE);
        send_char(8'h7E, FF_HOLD_GLITCH);
        write_reg(REG_STOP_HALF, CFG_DATA_W'(4));
        send_char(8'h96, FF_NONE);
        send_char(8'h96, FF_HOLD_GLITCH);
        send_char(8'h96, FF_STOP_LOW);
        // odd period gives a rounded extra interval
        set_format(5, 7, PAR_EVEN, 3);
        send_char(8'h55, FF_NONE);
        send_char(8'h2A, FF_HOLD_GLITCH);
    endtask

    // start bit that does not survive to its centre
    task automatic test_start_failure();
        set_format(6, 8, PAR_NONE, 2);
        send_char(8'hFF, FF_SHORT_START);
        set_format(4, 8, PAR_NONE, 2);
        send_char(8'h00, FF_SHORT_START);
        send_char(8'h69, FF_NONE);
    endtask

    // register values outside the usable range are clamped
    task automatic test_register_clamps();
        set_format(0, 0, PAR_NONE, 0);
        send_char(8'h01, FF_NONE);
        set_format(3, 15, PAR_ODD, 7);
        send_char(8'hB7, FF_NONE);
        set_format(4, 9, PAR_EVEN, 1);
        send_char(8'h4D, FF_NONE);
    endtask

    // long bit period, sender without gaps to keep the run short
    task automatic test_long_period();
        src_gaps = 1'b0;
        set_format(40, 1, PAR_NONE, 2);
        send_char(8'h00, FF_SHORT_START);
        send_char(8'h01, FF_NONE);
        src_gaps = 1'b1;
    endtask

    // random formats and characters, mostly well formed, up to the sample budget
    task automatic test_random_traffic();
        int unsigned r;
        int unsigned period;
        frame_fault_t fault;
        while (samples_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                period = $urandom_range(4, 8);
            else if (r < 90)
                period = $urandom_range(9, 16);
            else if (r < 96)
                period = $urandom_range(0, 3);
            else
                period = $urandom_range(17, 24);
            write_reg(REG_BIT_PERIOD, CFG_DATA_W'(period));
            // narrow registers get junk in the unused upper bits
            write_reg(REG_DATA_BITS, CFG_DATA_W'(($urandom_range(0, 99) < 80)
                      ? $urandom_range(1, 8) : $urandom_range(0, 15))
                      | (CFG_DATA_W'($urandom_range(0, 16'hFFFF)) & 16'hFFF0));
            write_reg(REG_PARITY_MODE, CFG_DATA_W'($urandom_range(0, 3))
                      | (CFG_DATA_W'($urandom_range(0, 16'hFFFF)) & 16'hFFFC));
            write_reg(REG_STOP_HALF, CFG_DATA_W'(($urandom_range(0, 99) < 75)
                      ? $urandom_range(2, 4) : $urandom_range(0, 7))
                      | (CFG_DATA_W'($urandom_range(0, 16'hFFFF)) & 16'hFFF8));
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4))
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    fault = FF_NONE;
                else if (r < 63)
                    fault = FF_PARITY;
                else if (r < 71)
                    fault = FF_STOP_LOW;
                else if (r < 79)
                    fault = FF_HOLD_GLITCH;
                else if (r < 86)
                    fault = FF_SHORT_START;
                else if (r < 93)
                    fault = FF_NOISE;
                else
                    fault = FF_PARITY_AND_STOP;
                if (samples_sent < ITEM_TARGET)
                    send_char(8'($urandom_range(0, 255)), fault);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_decoder();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_format();
        test_parity_check();
        test_stop_lengths();
        test_start_failure();
        test_register_clamps();
        test_long_period();
        test_random_traffic();

        // let every character come out, then wait in quiet before the verdict
        drain_results();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0 && pending_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
